// ===== hdl/pxy_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pxy_pkg;

    // Fixed-point layout of the sine/cosine series: 62 fraction bits.
    localparam int Q_W  = 62;
    localparam int T_W  = 63;
    localparam int NTERM = 11;

    // pi * 2^60, split into the upper 30 and lower 32 bits.
    localparam logic [29:0] PI_HI = 30'h3243F6A8;
    localparam logic [31:0] PI_LO = 32'h885A308D;

    localparam logic [T_W-1:0] ONE_Q62 = 63'h4000_0000_0000_0000;

    typedef enum logic [1:0] {
        REG_POSE_X       = 2'd0,
        REG_POSE_Y       = 2'd1,
        REG_POSE_HEADING = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] range_dist;
        logic [2:0]  oct;
    } t_side;

    // One beat of the series pipeline: both partial sums and their last terms.
    typedef struct packed {
        logic           vld;
        t_side          side;
        logic [Q_W-1:0] t2;
        logic [T_W-1:0] s_term;
        logic [T_W-1:0] s_sum;
        logic [T_W-1:0] c_term;
        logic [T_W-1:0] c_sum;
    } t_tay;

endpackage

`default_nettype wire

// ===== hdl/pxy_term.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pxy_term #(
    parameter int K = 1
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  pxy_pkg::t_tay     i_tay,
    output pxy_pkg::t_tay     o_tay
);

    // Divisors of the sine and cosine terms of degree 2K+1 and 2K.
    localparam int D_S = 2 * K * (2 * K + 1);
    localparam int D_C = (2 * K - 1) * (2 * K);
    localparam logic [64:0] TWO_64 = {1'b1, 64'b0};
    localparam logic [64:0] M_S65 = TWO_64 / 65'(D_S);
    localparam logic [64:0] M_C65 = TWO_64 / 65'(D_C);
    localparam logic [9:0]  DIV   [2] = '{10'(D_S), 10'(D_C)};
    localparam logic [63:0] RECIP [2] = '{M_S65[63:0], M_C65[63:0]};
    localparam bit SUB = (K % 2) == 1;

    localparam int QW = pxy_pkg::Q_W;
    localparam int TW = pxy_pkg::T_W;

    logic [TW-1:0] w_term [2];
    logic [TW-1:0] w_sum  [2];

    logic              r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    pxy_pkg::t_side    r1_side, r2_side, r3_side, r4_side, r5_side;
    logic [QW-1:0]     r1_t2, r2_t2, r3_t2, r4_t2, r5_t2;

    logic [63:0]   r1_ll [2], r1_lh [2], r1_hl [2], r1_hh [2];
    logic [63:0]   r3_ll [2], r3_lh [2], r3_hl [2], r3_hh [2];
    logic [TW-1:0] r1_sum [2], r2_sum [2], r3_sum [2], r4_sum [2], r5_sum [2];
    logic [QW-1:0] r2_y [2], r3_y [2], r4_y [2];
    logic [QW-1:0] r4_qe [2];
    logic [TW-1:0] r5_term [2];

    logic [127:0]  w2_prod [2];
    logic [127:0]  w4_prod [2];
    logic [QW-1:0] n2_y [2];
    logic [QW-1:0] n4_qe [2];
    logic [20:0]   w5_qd [2];
    logic [10:0]   w5_rem [2];
    logic [QW-1:0] w5_q [2];
    logic [TW-1:0] n5_term [2];
    logic [TW-1:0] n5_sum [2];

    assign w_term[0] = i_tay.s_term;
    assign w_term[1] = i_tay.c_term;
    assign w_sum[0]  = i_tay.s_sum;
    assign w_sum[1]  = i_tay.c_sum;

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            w2_prod[j] = (128'(r1_hh[j]) << 64) + (128'(r1_lh[j]) << 32)
                       + (128'(r1_hl[j]) << 32) + 128'(r1_ll[j]);
            n2_y[j]    = w2_prod[j][123:62];
            w4_prod[j] = (128'(r3_hh[j]) << 64) + (128'(r3_lh[j]) << 32)
                       + (128'(r3_hl[j]) << 32) + 128'(r3_ll[j]);
            n4_qe[j]   = w4_prod[j][125:64];
            // The reciprocal estimate is at most one low, and the true
            // remainder is below twice the divisor, so 11 bits are exact.
            w5_qd[j]   = 21'(r4_qe[j][10:0]) * 21'(DIV[j]);
            w5_rem[j]  = r4_y[j][10:0] - w5_qd[j][10:0];
            w5_q[j]    = r4_qe[j] + QW'(w5_rem[j] >= 11'(DIV[j]));
            n5_term[j] = {1'b0, w5_q[j]};
            n5_sum[j]  = SUB ? (r4_sum[j] - n5_term[j]) : (r4_sum[j] + n5_term[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            r1_vld <= i_tay.vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_side <= i_tay.side;
        r2_side <= r1_side;
        r3_side <= r2_side;
        r4_side <= r3_side;
        r5_side <= r4_side;
        r1_t2   <= i_tay.t2;
        r2_t2   <= r1_t2;
        r3_t2   <= r2_t2;
        r4_t2   <= r3_t2;
        r5_t2   <= r4_t2;
        for (int j = 0; j < 2; j++) begin
            r1_ll[j]   <= 64'(w_term[j][31:0])  * 64'(i_tay.t2[31:0]);
            r1_lh[j]   <= 64'(w_term[j][31:0])  * 64'(i_tay.t2[61:32]);
            r1_hl[j]   <= 64'(w_term[j][62:32]) * 64'(i_tay.t2[31:0]);
            r1_hh[j]   <= 64'(w_term[j][62:32]) * 64'(i_tay.t2[61:32]);
            r1_sum[j]  <= w_sum[j];
            r2_y[j]    <= n2_y[j];
            r2_sum[j]  <= r1_sum[j];
            r3_ll[j]   <= 64'(r2_y[j][31:0])  * 64'(RECIP[j][31:0]);
            r3_lh[j]   <= 64'(r2_y[j][31:0])  * 64'(RECIP[j][63:32]);
            r3_hl[j]   <= 64'(r2_y[j][61:32]) * 64'(RECIP[j][31:0]);
            r3_hh[j]   <= 64'(r2_y[j][61:32]) * 64'(RECIP[j][63:32]);
            r3_y[j]    <= r2_y[j];
            r3_sum[j]  <= r2_sum[j];
            r4_qe[j]   <= n4_qe[j];
            r4_y[j]    <= r3_y[j];
            r4_sum[j]  <= r3_sum[j];
            r5_term[j] <= n5_term[j];
            r5_sum[j]  <= n5_sum[j];
        end
    end

    always_comb begin
        o_tay.vld    = r5_vld;
        o_tay.side   = r5_side;
        o_tay.t2     = r5_t2;
        o_tay.s_term = r5_term[0];
        o_tay.s_sum  = r5_sum[0];
        o_tay.c_term = r5_term[1];
        o_tay.c_sum  = r5_sum[1];
    end

endmodule

`default_nettype wire

// ===== hdl/polar_point_to_world_xy.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A point accepted on start passes r0-r5, the series terms and r6-r8 to o_point_x/o_point_y with o_valid.
// Throughput: one point per cycle; busy stays low. Most of the depth comes from the eleven series
// terms, each a five-stage multiply, reciprocal divide and accumulate step.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset (synchronous, active low) clears the pipeline valid bits and the pose registers.
module polar_point_to_world_xy #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [15:0]        i_range_dist,
    input  wire logic signed [15:0] i_bearing,
    output logic                    o_valid,
    output logic signed [31:0]      o_point_x,
    output logic signed [31:0]      o_point_y
);

    localparam int SH = ANGLE_BITS - 3;
    localparam int QW = pxy_pkg::Q_W;
    localparam int NT = pxy_pkg::NTERM;

    // Configuration registers.
    logic [31:0] r_pose_x;
    logic [31:0] r_pose_y;
    logic [15:0] r_pose_heading;
    logic        w_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_x       <= 32'd0;
            r_pose_y       <= 32'd0;
            r_pose_heading <= 16'd0;
        end else if (w_wr) begin
            case (pxy_pkg::t_reg_idx'(paddr[3:2]))
                pxy_pkg::REG_POSE_X:       r_pose_x       <= pwdata;
                pxy_pkg::REG_POSE_Y:       r_pose_y       <= pwdata;
                pxy_pkg::REG_POSE_HEADING: r_pose_heading <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (pxy_pkg::t_reg_idx'(paddr[3:2]))
            pxy_pkg::REG_POSE_X:       prdata = r_pose_x;
            pxy_pkg::REG_POSE_Y:       prdata = r_pose_y;
            pxy_pkg::REG_POSE_HEADING: prdata = {16'd0, r_pose_heading};
            default:                   prdata = 32'd0;
        endcase
    end

    // Angle sum, brought to ANGLE_BITS bits per turn.
    logic [15:0]           w_asum;
    logic [ANGLE_BITS-1:0] w_p;

    assign w_asum = i_bearing + r_pose_heading;

    generate
        if (ANGLE_BITS > 16) begin : g_up
            assign w_p = {w_asum, {(ANGLE_BITS - 16){1'b0}}};
        end else if (ANGLE_BITS == 16) begin : g_eq
            assign w_p = w_asum;
        end else begin : g_dn
            localparam int DN = 16 - ANGLE_BITS;
            logic [15:0] w_rnd;
            // Round half up; the carry out of bit 15 wraps to angle zero.
            assign w_rnd = w_asum + 16'(1 << (DN - 1));
            assign w_p   = w_rnd[15:DN];
        end
    endgenerate

    logic                  r0_vld, r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    logic [15:0]           r0_range, r1_range, r2_range, r3_range, r4_range, r5_range;
    logic [ANGLE_BITS-1:0] r0_p;
    logic [2:0]            r1_oct, r2_oct, r3_oct, r4_oct, r5_oct;
    logic [SH:0]           r1_r;
    logic [SH:0]           n1_r;
    logic [SH+30:0]        r2_ph;
    logic [SH+32:0]        r2_pl;
    logic [63:0]           n3_t64;
    logic [QW-1:0]         r3_t, r4_t, r5_t;
    logic [63:0]           r4_ll, r4_lh, r4_hh;
    logic [127:0]          w5_prod;
    logic [QW-1:0]         r5_t2;

    // Odd octants are mirrored so the series always sees an angle in [0, pi/4].
    assign n1_r = r0_p[SH] ? ({1'b1, {SH{1'b0}}} - {1'b0, r0_p[SH-1:0]})
                           : {1'b0, r0_p[SH-1:0]};

    assign n3_t64  = (64'(r2_ph) << (32 - SH)) + 64'(r2_pl >> SH);
    assign w5_prod = (128'(r4_hh) << 64) + (128'(r4_lh) << 33) + 128'(r4_ll);

    always_ff @(posedge i_clk) begin
        r0_range <= i_range_dist;
        r0_p     <= w_p;
        r1_range <= r0_range;
        r1_oct   <= r0_p[ANGLE_BITS-1 -: 3];
        r1_r     <= n1_r;
        r2_range <= r1_range;
        r2_oct   <= r1_oct;
        r2_ph    <= (SH + 31)'(r1_r) * (SH + 31)'(pxy_pkg::PI_HI);
        r2_pl    <= (SH + 33)'(r1_r) * (SH + 33)'(pxy_pkg::PI_LO);
        r3_range <= r2_range;
        r3_oct   <= r2_oct;
        r3_t     <= n3_t64[QW-1:0];
        r4_range <= r3_range;
        r4_oct   <= r3_oct;
        r4_t     <= r3_t;
        r4_ll    <= 64'(r3_t[31:0])  * 64'(r3_t[31:0]);
        r4_lh    <= 64'(r3_t[31:0])  * 64'(r3_t[61:32]);
        r4_hh    <= 64'(r3_t[61:32]) * 64'(r3_t[61:32]);
        r5_range <= r4_range;
        r5_oct   <= r4_oct;
        r5_t     <= r4_t;
        r5_t2    <= w5_prod[123:62];
    end

    // Series terms, one pipeline section per degree pair.
    pxy_pkg::t_tay w_tay [NT+1];

    always_comb begin
        w_tay[0].vld             = r5_vld;
        w_tay[0].side.range_dist = r5_range;
        w_tay[0].side.oct        = r5_oct;
        w_tay[0].t2              = r5_t2;
        w_tay[0].s_term          = {1'b0, r5_t};
        w_tay[0].s_sum           = {1'b0, r5_t};
        w_tay[0].c_term          = pxy_pkg::ONE_Q62;
        w_tay[0].c_sum           = pxy_pkg::ONE_Q62;
    end

    generate
        for (genvar k = 1; k <= NT; k++) begin : g_term
            pxy_term #(
                .K(k)
            ) u_term (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_tay  (w_tay[k-1]),
                .o_tay  (w_tay[k])
            );
        end
    endgenerate

    // Round to 30 fraction bits, then apply octant symmetry.
    logic [63:0] w6_s, w6_c;
    logic [30:0] w6_s30, w6_c30;
    logic [2:0]  w6_oct;
    logic        w6_swap;

    assign w6_s    = 64'(w_tay[NT].s_sum) + 64'h8000_0000;
    assign w6_c    = 64'(w_tay[NT].c_sum) + 64'h8000_0000;
    assign w6_s30  = w6_s[62:32];
    assign w6_c30  = w6_c[62:32];
    assign w6_oct  = w_tay[NT].side.oct;
    assign w6_swap = w6_oct[0] ^ w6_oct[1];

    logic        r6_vld, r7_vld, r8_vld;
    logic [15:0] r6_range;
    logic [30:0] r6_sin, r6_cos;
    logic        r6_sin_neg, r6_cos_neg, r7_sin_neg, r7_cos_neg;
    logic [46:0] r7_px, r7_py;
    logic [47:0] w8_rx, w8_ry;
    logic [31:0] w8_qx, w8_qy;
    logic [31:0] r8_x, r8_y;

    assign w8_rx = 48'(r7_px) + 48'h2000_0000;
    assign w8_ry = 48'(r7_py) + 48'h2000_0000;
    assign w8_qx = 32'(w8_rx[47:30]);
    assign w8_qy = 32'(w8_ry[47:30]);

    always_ff @(posedge i_clk) begin
        r6_range   <= w_tay[NT].side.range_dist;
        r6_sin     <= w6_swap ? w6_c30 : w6_s30;
        r6_cos     <= w6_swap ? w6_s30 : w6_c30;
        r6_sin_neg <= w6_oct[2];
        r6_cos_neg <= w6_oct[2] ^ w6_oct[1];
        r7_px      <= 47'(r6_range) * 47'(r6_cos);
        r7_py      <= 47'(r6_range) * 47'(r6_sin);
        r7_sin_neg <= r6_sin_neg;
        r7_cos_neg <= r6_cos_neg;
        r8_x       <= r7_cos_neg ? (r_pose_x - w8_qx) : (r_pose_x + w8_qx);
        r8_y       <= r7_sin_neg ? (r_pose_y - w8_qy) : (r_pose_y + w8_qy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
        end else begin
            r0_vld <= start & ~busy;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= w_tay[NT].vld;
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
        end
    end

    assign o_valid   = r8_vld;
    assign o_point_x = r8_x;
    assign o_point_y = r8_y;

endmodule

`default_nettype wire
